@@ hw/rtl/esc_pkg.sv @@
// Shared types, constants and helpers for the environmental sensor compensation block.
package esc_pkg;

    localparam int unsigned AdcW     = 20;
    localparam int unsigned ReadingW = 33;
    localparam int unsigned CfgW     = 64;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned StepW    = 4;

    typedef enum logic [1:0] {
        OP_TEMP  = 2'd0,
        OP_PRESS = 2'd1,
        OP_HUMID = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [CfgIdxW-1:0] REG_TEMP       = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LAST = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUMID_A    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_HUMID_B    = 3'd5;

    // Pressure steps that need special handling in the sequencer.
    localparam logic [StepW-1:0] STEP_PRESS_CHECK  = 4'd5;
    localparam logic [StepW-1:0] STEP_PRESS_DIVIDE = 4'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             start;
        logic             mul_go;
        logic             wb;
        logic             div_go;
        logic             div_wb;
        logic             fault_set;
        logic             finish;
        logic [StepW-1:0] step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic v1_zero;
    } sts_t;

    function automatic logic [StepW-1:0] last_step(input op_t op);
        logic [StepW-1:0] s;
        unique case (op)
            OP_TEMP:  s = 4'd3;
            OP_PRESS: s = 4'd9;
            OP_HUMID: s = 4'd7;
            default:  s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/env_sensor_compensation.sv @@
// Top level of the environmental sensor compensation block.
//
// Usage: a raw converter sample enters on the slave stream (s_tdata holds the
// 20-bit reading, s_tuser the kind: temperature, pressure or humidity). One
// compensated result leaves on the master stream per input transfer, in order.
// Calibration words are loaded through the plain write port; the user must do
// so only while idle, as the block does not enforce it. Every product runs on
// one shared multiplier in steps (operand load, three 32x32 partial products,
// status wait and writeback), and the pressure divide runs one quotient bit
// per cycle. An unused kind code skips every step and goes to the final load.
// One sample is worked on at a time; a new one is taken once the previous
// result has been placed in the output register. When the receiver stalls,
// the finished result waits in that register and the next sample can still
// be computed, holding only at the final load until the register frees up.
// Reset clears all calibration registers, the stored fine temperature and
// the output stream valid flag.
module env_sensor_compensation (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [esc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [esc_pkg::CfgW-1:0]       cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [19:0] raw_sample
    input  logic [1:0]                     s_tuser,   // [1:0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // [32:0] reading
    output logic                           m_tuser    // [0] divide_fault
);

    esc_pkg::cmd_t                cmd;
    esc_pkg::sts_t                sts;
    esc_pkg::op_t                 in_op;
    logic [esc_pkg::ReadingW-1:0] reading;

    assign in_op = esc_pkg::op_t'(s_tuser);

    // The controller owns the handshakes and the step sequence.
    esc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds calibration, working values and the result register.
    esc_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_adc      (s_tdata[19:0]),
        .in_op       (in_op),
        .cmd         (cmd),
        .sts         (sts),
        .out_reading (reading),
        .out_fault   (m_tuser)
    );

    assign m_tdata = {7'd0, reading};

endmodule

@@ hw/rtl/esc_divider.sv @@
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
module esc_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [64:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb begin
        shifted   = {rem_reg[63:0], num_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (go) begin
            num_next  = dividend[63] ? (64'd0 - dividend) : dividend;
            den_next  = divisor[63] ? (64'd0 - divisor) : divisor;
            neg_next  = dividend[63] ^ divisor[63];
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!diff[64]) begin
                rem_next = diff;
                num_next = {num_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                num_next = {num_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (64'd0 - num_reg) : num_reg;

endmodule

@@ hw/rtl/esc_datapath.sv @@
// Datapath: calibration registers, working registers, shared multiplier and result register.
module esc_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [esc_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [esc_pkg::CfgW-1:0]         cfg_wdata,
    input  logic [esc_pkg::AdcW-1:0]         in_adc,
    input  esc_pkg::op_t                     in_op,
    input  esc_pkg::cmd_t                    cmd,
    output esc_pkg::sts_t                    sts,
    output logic [esc_pkg::ReadingW-1:0]     out_reading,
    output logic                             out_fault
);

    logic [47:0] temp_reg;
    logic [63:0] plow_reg, phigh_reg;
    logic [15:0] plast_reg;
    logic [47:0] huma_reg;
    logic [23:0] humb_reg;
    logic [31:0] fine_reg, fine_next;

    esc_pkg::op_t          op_reg;
    logic [esc_pkg::AdcW-1:0] adc_reg;
    logic [63:0] r0_reg, r0_next, r1_reg, r1_next, r2_reg, r2_next, r3_reg, r3_next;
    logic [esc_pkg::ReadingW-1:0] res_reg, res_next;
    logic        fault_reg, fault_next;
    logic [esc_pkg::ReadingW-1:0] out_reading_reg;
    logic        out_fault_reg;

    // Shared multiplier: low 64 bits of a 64x64 product from three 32x32 products.
    logic [63:0] ma_reg, mb_reg, pp0_reg;
    logic [31:0] pph_reg;
    logic [1:0]  mcnt_reg;
    logic        mbusy_reg, mdone_reg;
    logic [63:0] opa, opb, prod;
    logic [31:0] lo32;

    logic        div_done;
    logic [63:0] div_q;

    // Coefficients, sign-extended where signed.
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
    logic [31:0] d1, d2, hv, hsub, hfin;
    logic [63:0] praw, pacc, pfin;

    assign t1 = {48'd0, temp_reg[15:0]};
    assign t2 = {{48{temp_reg[31]}}, temp_reg[31:16]};
    assign t3 = {{48{temp_reg[47]}}, temp_reg[47:32]};
    assign p1 = {48'd0, plow_reg[15:0]};
    assign p2 = {{48{plow_reg[31]}}, plow_reg[31:16]};
    assign p3 = {{48{plow_reg[47]}}, plow_reg[47:32]};
    assign p4 = {{48{plow_reg[63]}}, plow_reg[63:48]};
    assign p5 = {{48{phigh_reg[15]}}, phigh_reg[15:0]};
    assign p6 = {{48{phigh_reg[31]}}, phigh_reg[31:16]};
    assign p7 = {{48{phigh_reg[47]}}, phigh_reg[47:32]};
    assign p8 = {{48{phigh_reg[63]}}, phigh_reg[63:48]};
    assign p9 = {{48{plast_reg[15]}}, plast_reg};
    assign h1 = {56'd0, huma_reg[7:0]};
    assign h2 = {{48{huma_reg[23]}}, huma_reg[23:8]};
    assign h3 = {56'd0, huma_reg[31:24]};
    assign h4 = {{48{huma_reg[47]}}, huma_reg[47:32]};
    assign h5 = {{48{humb_reg[15]}}, humb_reg[15:0]};
    assign h6 = {{56{humb_reg[23]}}, humb_reg[23:16]};

    assign d1   = {15'd0, adc_reg[19:3]} - {15'd0, t1[15:0], 1'b0};
    assign d2   = {16'd0, adc_reg[19:4]} - t1[31:0];
    assign praw = 64'd1048576 - {44'd0, adc_reg};
    assign prod = pp0_reg + {pph_reg, 32'd0};
    assign lo32 = prod[31:0];

    esc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (cmd.div_go),
        .dividend (r1_reg),
        .divisor  (r3_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Operand selection for each step.
    always_comb begin
        opa = '0;
        opb = '0;
        unique case (op_reg)
            esc_pkg::OP_TEMP: begin
                unique case (cmd.step)
                    4'd0:    begin opa = {32'd0, d1}; opb = t2; end
                    4'd1:    begin opa = {32'd0, d2}; opb = {32'd0, d2}; end
                    4'd2:    begin opa = r1_reg; opb = t3; end
                    default: begin opa = {32'd0, fine_reg}; opb = 64'd5; end
                endcase
            end
            esc_pkg::OP_PRESS: begin
                unique case (cmd.step)
                    4'd0:    begin opa = r0_reg; opb = r0_reg; end
                    4'd1:    begin opa = r1_reg; opb = p6; end
                    4'd2:    begin opa = r0_reg; opb = p5; end
                    4'd3:    begin opa = r1_reg; opb = p3; end
                    4'd4:    begin opa = r0_reg; opb = p2; end
                    4'd5:    begin opa = (64'd1 << 47) + r3_reg; opb = p1; end
                    4'd6:    begin opa = (praw << 31) - r2_reg; opb = 64'd3125; end
                    4'd7:    begin opa = p9; opb = 64'($signed(r1_reg) >>> 13); end
                    4'd8:    begin opa = r2_reg; opb = 64'($signed(r1_reg) >>> 13); end
                    default: begin opa = p8; opb = r1_reg; end
                endcase
            end
            esc_pkg::OP_HUMID: begin
                unique case (cmd.step)
                    4'd0:    begin opa = h5; opb = r0_reg; end
                    4'd1:    begin opa = r0_reg; opb = h6; end
                    4'd2:    begin opa = r0_reg; opb = h3; end
                    4'd3:    begin opa = r2_reg; opb = r3_reg; end
                    4'd4:    begin opa = r2_reg; opb = h2; end
                    4'd5:    begin opa = r1_reg; opb = r2_reg; end
                    4'd6:    begin opa = r3_reg; opb = r3_reg; end
                    default: begin opa = r3_reg; opb = h1; end
                endcase
            end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    // Writeback of each step's product.
    always_comb begin
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        r2_next    = r2_reg;
        r3_next    = r3_reg;
        fine_next  = fine_reg;
        res_next   = res_reg;
        fault_next = fault_reg;
        hsub = {2'd0, adc_reg[15:0], 14'd0} - {h4[11:0], 20'd0} - lo32 + 32'd16384;
        hv   = r0_reg[31:0] - 32'($signed(lo32) >>> 4);
        hfin = hv[31] ? 32'd0 : ((hv > 32'd419430400) ? 32'd419430400 : hv);
        pacc = r1_reg + r2_reg + 64'($signed(prod) >>> 19);
        pfin = 64'($signed(pacc) >>> 8) + (p7 << 4);
        if (cmd.start) begin
            res_next   = '0;
            fault_next = 1'b0;
            if (in_op == esc_pkg::OP_PRESS) begin
                r0_next = {{32{fine_reg[31]}}, fine_reg} - 64'd128000;
            end else begin
                r0_next = {32'd0, fine_reg - 32'd76800};
            end
        end else if (cmd.fault_set) begin
            res_next   = '0;
            fault_next = 1'b1;
        end else if (cmd.div_wb) begin
            r1_next = div_q;
        end else if (cmd.wb) begin
            unique case (op_reg)
                esc_pkg::OP_TEMP: begin
                    unique case (cmd.step)
                        4'd0: r0_next = {32'd0, 32'($signed(lo32) >>> 11)};
                        4'd1: r1_next = {32'd0, 32'($signed(lo32) >>> 12)};
                        4'd2: begin
                            r1_next   = {32'd0, 32'($signed(lo32) >>> 14)};
                            fine_next = r0_reg[31:0] + 32'($signed(lo32) >>> 14);
                        end
                        default: begin
                            hv       = lo32 + 32'd128;
                            res_next = {hv[31], 32'($signed(hv) >>> 8)};
                        end
                    endcase
                end
                esc_pkg::OP_PRESS: begin
                    unique case (cmd.step)
                        4'd0: r1_next = prod;
                        4'd1: r2_next = prod;
                        4'd2: r2_next = r2_reg + (prod << 17) + (p4 << 35);
                        4'd3: r3_next = 64'($signed(prod) >>> 8);
                        4'd4: r3_next = r3_reg + (prod << 12);
                        4'd5: r3_next = 64'($signed(prod) >>> 33);
                        4'd6: r1_next = prod;
                        4'd7: r2_next = prod;
                        4'd8: r2_next = 64'($signed(prod) >>> 25);
                        default: begin
                            r0_next = 64'($signed(prod) >>> 19);
                            if (pfin[63]) begin
                                res_next = '0;
                            end else if (pfin[63:32] != 32'd0) begin
                                res_next = {1'b0, 32'hFFFF_FFFF};
                            end else begin
                                res_next = {1'b0, pfin[31:0]};
                            end
                        end
                    endcase
                end
                esc_pkg::OP_HUMID: begin
                    unique case (cmd.step)
                        4'd0: r1_next = {32'd0, 32'($signed(hsub) >>> 15)};
                        4'd1: r2_next = {32'd0, 32'($signed(lo32) >>> 10)};
                        4'd2: r3_next = {32'd0, 32'($signed(lo32) >>> 11) + 32'd32768};
                        4'd3: r2_next = {32'd0, 32'($signed(lo32) >>> 10) + 32'd2097152};
                        4'd4: begin
                            hv      = lo32 + 32'd8192;
                            r2_next = {32'd0, 32'($signed(hv) >>> 14)};
                        end
                        4'd5: begin
                            r0_next = {32'd0, lo32};
                            r3_next = {32'd0, 32'($signed(lo32) >>> 15)};
                        end
                        4'd6: r3_next = {32'd0, 32'($signed(lo32) >>> 7)};
                        default: res_next = {13'd0, hfin[31:12]};
                    endcase
                end
                default: res_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            plast_reg <= '0;
            huma_reg  <= '0;
            humb_reg  <= '0;
            fine_reg  <= '0;
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    esc_pkg::REG_TEMP:       temp_reg  <= cfg_wdata[47:0];
                    esc_pkg::REG_PRESS_LOW:  plow_reg  <= cfg_wdata;
                    esc_pkg::REG_PRESS_HIGH: phigh_reg <= cfg_wdata;
                    esc_pkg::REG_PRESS_LAST: plast_reg <= cfg_wdata[15:0];
                    esc_pkg::REG_HUMID_A:    huma_reg  <= cfg_wdata[47:0];
                    esc_pkg::REG_HUMID_B:    humb_reg  <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            fine_reg <= fine_next;
            if (cmd.mul_go) begin
                mbusy_reg <= 1'b1;
                mdone_reg <= 1'b0;
                mcnt_reg  <= '0;
            end else if (mbusy_reg) begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd2) begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
        end
        if (cmd.mul_go) begin
            ma_reg <= opa;
            mb_reg <= opb;
        end else if (mbusy_reg) begin
            priority case (mcnt_reg)
                2'd0:    pp0_reg <= ma_reg[31:0] * mb_reg[31:0];
                2'd1:    pph_reg <= 32'(ma_reg[31:0] * mb_reg[63:32]);
                default: pph_reg <= pph_reg + 32'(ma_reg[63:32] * mb_reg[31:0]);
            endcase
        end
        if (cmd.start) begin
            op_reg  <= in_op;
            adc_reg <= in_adc;
        end
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        r2_reg    <= r2_next;
        r3_reg    <= r3_next;
        res_reg   <= res_next;
        fault_reg <= fault_next;
        if (cmd.finish) begin
            out_reading_reg <= res_reg;
            out_fault_reg   <= fault_reg;
        end
    end

    assign sts.mul_done = mdone_reg;
    assign sts.div_done = div_done;
    assign sts.v1_zero  = (r3_reg == 64'd0);
    assign out_reading  = out_reading_reg;
    assign out_fault    = out_fault_reg;

endmodule

@@ hw/rtl/esc_ctrl.sv @@
// Controller: sequences multiply, divide and writeback steps for one sample.
module esc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  esc_pkg::op_t  in_op,
    output logic          m_tvalid,
    input  logic          m_tready,
    output esc_pkg::cmd_t cmd,
    input  esc_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_WAIT, ST_WB, ST_CHK, ST_DIV, ST_DWAIT, ST_FIN
    } state_t;

    state_t                    state_reg, state_next;
    esc_pkg::op_t              op_reg, op_next;
    logic [esc_pkg::StepW-1:0] step_reg, step_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        cmd.step      = step_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    op_next    = in_op;
                    step_next  = '0;
                    state_next = (in_op == esc_pkg::OP_NONE) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_go = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.mul_done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.wb = 1'b1;
                if (step_reg == esc_pkg::last_step(op_reg)) begin
                    state_next = ST_FIN;
                end else if (op_reg == esc_pkg::OP_PRESS &&
                             step_reg == esc_pkg::STEP_PRESS_CHECK) begin
                    state_next = ST_CHK;
                end else if (op_reg == esc_pkg::OP_PRESS &&
                             step_reg == esc_pkg::STEP_PRESS_DIVIDE) begin
                    state_next = ST_DIV;
                end else begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_MUL;
                end
            end
            ST_CHK: begin
                if (sts.v1_zero) begin
                    cmd.fault_set = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DIV: begin
                cmd.div_go = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (sts.div_done) begin
                    cmd.div_wb = 1'b1;
                    step_next  = step_reg + 4'd1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= esc_pkg::OP_NONE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= 4'd9)
        else $error("step counter out of range");

    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid_reg)
        else $error("finished result not presented");

    a_div_press: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_go |-> (op_reg == esc_pkg::OP_PRESS && step_reg == esc_pkg::STEP_PRESS_DIVIDE))
        else $error("divider started outside pressure sequence");

endmodule

@@ sim/tb_env_sensor_compensation.sv @@
// Self-checking testbench for the environmental sensor compensation block.
`timescale 1ns / 1ps

module tb_env_sensor_compensation;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [esc_pkg::CfgIdxW-1:0]  cfg_index;
    logic [esc_pkg::CfgW-1:0]     cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [23:0]                  s_tdata;   // [19:0] raw_sample
    logic [1:0]                   s_tuser;   // [1:0] opcode
    logic                         m_tvalid;
    logic                         m_tready;
    logic [39:0]                  m_tdata;   // [32:0] reading
    logic                         m_tuser;   // [0] divide_fault

    env_sensor_compensation dut (.*);

    // One compensated result as the block should deliver it.
    typedef struct packed {
        logic [32:0] reading;
        logic        fault;
    } sensor_result_t;

    // Shadow copy of the calibration registers and the fine temperature.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_press_p9;
    logic [47:0] cal_humid_a;
    logic [23:0] cal_humid_b;
    logic signed [31:0] fine_temp;

    sensor_result_t pending_results[$];
    int  error_count;
    int  sent_count;
    int  checked_count;
    int  fault_count;
    int  rx_wait;         // cycles the receiver still waits before the next transfer
    longint cycle_count;
    bit  hold_off;        // long receiver stall requested by the backpressure test
    bit  rx_random;       // receiver inserts random stalls when set

    localparam longint CycleLimit = 2_000_000;

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb_env_sensor_compensation: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: integer compensation at the block's own widths.
    // ------------------------------------------------------------------
    function automatic sensor_result_t compensate(esc_pkg::op_t op, logic [19:0] adc);
        sensor_result_t r;
        logic signed [31:0] t1, t2, t3, d1, d2, v1s, v2s, tr;
        logic signed [63:0] q1, q2, pp, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] num, mag_a, mag_b, quo;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, hv, ha, hb, hs;
        r = '0;
        case (op)
            esc_pkg::OP_TEMP: begin
                t1 = {16'd0, cal_temp[15:0]};
                t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
                t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
                d1 = $signed({12'd0, adc} >> 3) - (t1 <<< 1);
                d2 = $signed({12'd0, adc} >> 4) - t1;
                v1s = (d1 * t2) >>> 11;
                v2s = (((d2 * d2) >>> 12) * t3) >>> 14;
                fine_temp = v1s + v2s;
                tr = (fine_temp * 32'sd5 + 32'sd128) >>> 8;
                r.reading = {tr[31], tr};
            end
            esc_pkg::OP_PRESS: begin
                p1 = {48'd0, cal_press_lo[15:0]};
                p2 = {{48{cal_press_lo[31]}}, cal_press_lo[31:16]};
                p3 = {{48{cal_press_lo[47]}}, cal_press_lo[47:32]};
                p4 = {{48{cal_press_lo[63]}}, cal_press_lo[63:48]};
                p5 = {{48{cal_press_hi[15]}}, cal_press_hi[15:0]};
                p6 = {{48{cal_press_hi[31]}}, cal_press_hi[31:16]};
                p7 = {{48{cal_press_hi[47]}}, cal_press_hi[47:32]};
                p8 = {{48{cal_press_hi[63]}}, cal_press_hi[63:48]};
                p9 = {{48{cal_press_p9[15]}}, cal_press_p9};
                q1 = 64'(fine_temp) - 64'sd128000;
                q2 = q1 * q1 * p6;
                q2 = q2 + ((q1 * p5) <<< 17);
                q2 = q2 + (p4 <<< 35);
                q1 = ((q1 * q1 * p3) >>> 8) + ((q1 * p2) <<< 12);
                q1 = (((64'sd1 <<< 47) + q1) * p1) >>> 33;
                if (q1 == 0) begin
                    r.fault = 1'b1;
                end else begin
                    pp = 64'sd1048576 - $signed({44'd0, adc});
                    num = ((pp <<< 31) - q2) * 64'sd3125;
                    // Truncating divide on magnitudes; wrap matches two's complement.
                    mag_a = num[63] ? -num : num;
                    mag_b = q1[63] ? -q1 : q1;
                    quo = $signed(64'($unsigned(mag_a) / $unsigned(mag_b)));
                    pp = (num[63] != q1[63]) ? -quo : quo;
                    q1 = (p9 * (pp >>> 13) * (pp >>> 13)) >>> 25;
                    q2 = (p8 * pp) >>> 19;
                    pp = ((pp + q1 + q2) >>> 8) + (p7 <<< 4);
                    if (pp < 0)
                        r.reading = '0;
                    else if (pp > 64'sh0_FFFF_FFFF)
                        r.reading = 33'h0_FFFF_FFFF;
                    else
                        r.reading = pp[32:0];
                end
            end
            esc_pkg::OP_HUMID: begin
                h1 = {24'd0, cal_humid_a[7:0]};
                h2 = {{16{cal_humid_a[23]}}, cal_humid_a[23:8]};
                h3 = {24'd0, cal_humid_a[31:24]};
                h4 = {{16{cal_humid_a[47]}}, cal_humid_a[47:32]};
                h5 = {{16{cal_humid_b[15]}}, cal_humid_b[15:0]};
                h6 = {{24{cal_humid_b[23]}}, cal_humid_b[23:16]};
                hv = fine_temp - 32'sd76800;
                ha = ($signed({16'd0, adc[15:0]}) <<< 14) - (h4 <<< 20) - h5 * hv
                     + 32'sd16384;
                ha = ha >>> 15;
                hb = ((((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32'sd32768)) >>> 10)
                     + 32'sd2097152;
                hb = (hb * h2 + 32'sd8192) >>> 14;
                hv = ha * hb;
                hs = hv >>> 15;
                hv = hv - ((((hs * hs) >>> 7) * h1) >>> 4);
                if (hv < 0)
                    hv = 0;
                if (hv > 32'sd419430400)
                    hv = 32'sd419430400;
                r.reading = {13'd0, hv[31:12]};
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------
    task automatic write_reg(logic [esc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            esc_pkg::REG_TEMP:       cal_temp = val[47:0];
            esc_pkg::REG_PRESS_LOW:  cal_press_lo = val;
            esc_pkg::REG_PRESS_HIGH: cal_press_hi = val;
            esc_pkg::REG_PRESS_LAST: cal_press_p9 = val[15:0];
            esc_pkg::REG_HUMID_A:    cal_humid_a = val[47:0];
            esc_pkg::REG_HUMID_B:    cal_humid_b = val[23:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Sends one sample; the prediction is queued when the transfer completes.
    task automatic send_sample(esc_pkg::op_t op, logic [19:0] adc, bit gaps);
        int pause;
        pause = gaps ? $urandom_range(0, 17) : 0;
        repeat (pause) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, adc};
        s_tuser  = op;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(compensate(op, adc));
        sent_count++;
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tdata  = {4'd0, 20'($urandom)};
        s_tuser  = 2'($urandom);
    endtask

    // Waits until every expected result has come back, then lets the block settle.
    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (160) @(negedge aclk);
    endtask

    // Typical-looking calibration: datasheet-like magnitudes with random jitter.
    task automatic load_typical_cal();
        write_reg(esc_pkg::REG_TEMP, {16'($urandom_range(0, 100) - 50), 16'd26435,
                                      16'($urandom_range(27000, 28500))});
        write_reg(esc_pkg::REG_PRESS_LOW, {16'd2855,
                                           16'hD0A8 + 16'($urandom_range(0, 255)),
                                           16'hD678, 16'($urandom_range(36000, 38000))});
        write_reg(esc_pkg::REG_PRESS_HIGH, {16'hE830, 16'd15500, 16'hFFF9, 16'd140});
        write_reg(esc_pkg::REG_PRESS_LAST, 16'd4000 + 16'($urandom_range(0, 1000)));
        write_reg(esc_pkg::REG_HUMID_A, {16'd339, 8'd0, 16'd362, 8'd75});
        write_reg(esc_pkg::REG_HUMID_B, {8'd30, 16'd50});
    endtask

    task automatic load_random_cal();
        write_reg(esc_pkg::REG_TEMP, {$urandom, $urandom});
        write_reg(esc_pkg::REG_PRESS_LOW, {$urandom, $urandom});
        write_reg(esc_pkg::REG_PRESS_HIGH, {$urandom, $urandom});
        write_reg(esc_pkg::REG_PRESS_LAST, {$urandom, $urandom});
        write_reg(esc_pkg::REG_HUMID_A, {$urandom, $urandom});
        write_reg(esc_pkg::REG_HUMID_B, {$urandom, $urandom});
    endtask

    function automatic logic [19:0] random_adc();
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return 20'hFFFFF;
            2: return 20'h00000;
            default: return 20'($urandom_range(300000, 600000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver and checker.
    // ------------------------------------------------------------------
    // In random mode the receiver waits a freshly drawn number of cycles
    // before each result transfer.
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (!rx_random) begin
            m_tready <= 1'b1;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sensor_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            rx_wait <= $urandom_range(0, 17);
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: reading %h", m_tdata[32:0]);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                checked_count++;
                if (m_tuser)
                    fault_count++;
                if (m_tdata[32:0] !== exp_res.reading) begin
                    $error("reading: expected %h, actual %h", exp_res.reading,
                           m_tdata[32:0]);
                    error_count++;
                end
                if (m_tuser !== exp_res.fault) begin
                    $error("divide_fault: expected %b, actual %b", exp_res.fault,
                           m_tuser);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Right after reset all coefficients are zero, so the pressure divisor is zero and faults.
    task automatic test_reset_state();
        send_sample(esc_pkg::OP_PRESS, 20'h80000, 1'b0);
        send_sample(esc_pkg::OP_HUMID, 20'hFFFFF, 1'b0);
        send_sample(esc_pkg::OP_TEMP, 20'h00000, 1'b0);
        send_sample(esc_pkg::OP_NONE, 20'h12345, 1'b0);
        drain();
    endtask

    // Field extremes and every kind, including the unused code.
    task automatic test_directed();
        load_typical_cal();
        send_sample(esc_pkg::OP_PRESS, 20'h00000, 1'b0);   // pressure before this test's temp samples
        send_sample(esc_pkg::OP_HUMID, 20'h0FFFF, 1'b0);
        send_sample(esc_pkg::OP_TEMP, 20'h7E000, 1'b0);
        send_sample(esc_pkg::OP_PRESS, 20'h50000, 1'b0);
        send_sample(esc_pkg::OP_PRESS, 20'hFFFFF, 1'b0);
        send_sample(esc_pkg::OP_PRESS, 20'h00000, 1'b0);
        send_sample(esc_pkg::OP_HUMID, 20'h00000, 1'b0);   // clamps low
        send_sample(esc_pkg::OP_HUMID, 20'hFFFFF, 1'b0);   // upper bits ignored
        send_sample(esc_pkg::OP_NONE, 20'hFFFFF, 1'b0);
        send_sample(esc_pkg::OP_TEMP, 20'hFFFFF, 1'b0);
        send_sample(esc_pkg::OP_TEMP, 20'h00000, 1'b0);
        send_sample(esc_pkg::OP_HUMID, 20'h06000, 1'b0);
        drain();
        // Extreme calibration words: all ones and sign-bit-only patterns.
        write_reg(esc_pkg::REG_TEMP, 48'hFFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_PRESS_LAST, 16'hFFFF);
        write_reg(esc_pkg::REG_HUMID_A, 48'hFFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_HUMID_B, 24'hFF_FFFF);
        send_sample(esc_pkg::OP_TEMP, 20'hFFFFF, 1'b0);
        send_sample(esc_pkg::OP_PRESS, 20'h00000, 1'b0);
        send_sample(esc_pkg::OP_HUMID, 20'hFFFFF, 1'b0);
        drain();
        write_reg(esc_pkg::REG_TEMP, 48'h8000_8000_0000);
        write_reg(esc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
        write_reg(esc_pkg::REG_PRESS_HIGH, 64'h8000_7FFF_8000_7FFF);
        write_reg(esc_pkg::REG_PRESS_LAST, 16'h8000);
        write_reg(esc_pkg::REG_HUMID_A, 48'h8000_FF80_00FF);
        write_reg(esc_pkg::REG_HUMID_B, 24'h80_8000);
        send_sample(esc_pkg::OP_TEMP, 20'h00000, 1'b0);
        send_sample(esc_pkg::OP_PRESS, 20'hFFFFF, 1'b0);
        send_sample(esc_pkg::OP_HUMID, 20'h0FFFF, 1'b0);
        drain();
    endtask

    // Receiver holds off for a long stretch while samples keep coming.
    task automatic test_backpressure();
        load_typical_cal();
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(negedge aclk);
                hold_off = 1'b0;
            end
            repeat (8) send_sample(esc_pkg::op_t'($urandom_range(0, 2)), random_adc(), 1'b0);
        join
        drain();
    endtask

    // Random samples in phases; each phase starts with a fresh calibration.
    task automatic test_random(int phases, int per_phase);
        esc_pkg::op_t op;
        for (int ph = 0; ph < phases; ph++) begin
            rx_random = (ph % 3) != 2;
            if (ph % 2 == 0)
                load_typical_cal();
            else
                load_random_cal();
            for (int i = 0; i < per_phase; i++) begin
                // Random kinds, mostly real ones, some unused codes.
                case ($urandom_range(0, 9))
                    0, 1, 2: op = esc_pkg::OP_TEMP;
                    3, 4, 5: op = esc_pkg::OP_PRESS;
                    6, 7, 8: op = esc_pkg::OP_HUMID;
                    default: op = esc_pkg::OP_NONE;
                endcase
                send_sample(op, random_adc(), ph % 3 != 2);
            end
            drain();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        hold_off  = 1'b0;
        rx_random = 1'b0;
        rx_wait   = 0;
        cal_temp = '0; cal_press_lo = '0; cal_press_hi = '0;
        cal_press_p9 = '0; cal_humid_a = '0; cal_humid_b = '0;
        fine_temp = '0;
        error_count = 0; sent_count = 0; checked_count = 0; fault_count = 0;
        cycle_count = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_directed();
        test_backpressure();
        test_random(10, 88);

        $display("Sent %0d samples, checked %0d results (%0d divide faults),",
                 sent_count, checked_count, fault_count);
        $display("across reset, extreme and random calibrations with stalls.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_env_sensor_compensation: clean");
        end else begin
            $display("tb_env_sensor_compensation: errors");
        end
        $finish;
    end

endmodule

@@ env_sensor_compensation.f @@
hw/rtl/esc_pkg.sv
hw/rtl/esc_divider.sv
hw/rtl/esc_datapath.sv
hw/rtl/esc_ctrl.sv
hw/rtl/env_sensor_compensation.sv
sim/tb_env_sensor_compensation.sv
